@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the pooled list unit.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/plmtf_pkg.sv @@
// Package of the pooled list move-to-front unit: payload types, codes, defaults.
// Depends on nothing.
package plmtf_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam logic [2:0] CMD_APPEND = 3'd0;
   localparam logic [2:0] CMD_PUSH   = 3'd1;
   localparam logic [2:0] CMD_POP    = 3'd2;
   localparam logic [2:0] CMD_FIND   = 3'd3;
   localparam logic [2:0] CMD_MOVE   = 3'd4;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_EMPTY    = 2'd2;
   localparam logic [1:0] STAT_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] data_out;
      logic [3:0]  slot_index;
      logic [4:0]  entry_count;
   } rsp_type;

   function automatic rsp_type make_rsp(input logic [1:0] status, input logic [31:0] data,
                                        input logic [3:0] slot, input logic [4:0] count);
      rsp_type r;
      r.status      = status;
      r.data_out    = data;
      r.slot_index  = slot;
      r.entry_count = count;
      return r;
   endfunction

endpackage

@@ sv/plmtf_ram.sv @@
// Simple dual-port memory of the pooled list unit: one write, one registered read.
// Depends on nothing.
module plmtf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/pooled_list_move_to_front_unit.sv @@
// Top level of the pooled list move-to-front unit: command sequencer and list pointers.
// Depends on plmtf_pkg, plmtf_ram and assert_macros.svh.
//
//   channel   ports                          handshake
//   request   start, busy, req_payload       taken when start && !busy
//   response  rsp_strobe, rsp_payload        one cycle per transaction, no stall
//
// Append and push pass through S_ALLOC (and S_LINK_TAIL for an append to a non-empty
// list), pop through S_POP; full, empty and unused codes are answered from idle. Find and
// move walk the list in S_WALK, with S_MOVE after it for a relinking move; the walk
// does one registered read of the value and link memories per entry.
// Reset is synchronous; no clearing pass: untouched slots are tracked by a fill count.
// The response is strobed for one cycle as the unit returns to idle.
`include "assert_macros.svh"

module pooled_list_move_to_front_unit #(
   parameter int CAPACITY = plmtf_pkg::CAPACITY_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  plmtf_pkg::req_type  req_payload,
   output logic                rsp_strobe,
   output plmtf_pkg::rsp_type  rsp_payload
);

   localparam int IW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam logic [LW-1:0] NULL_SLOT = LW'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_LINK_TAIL,
      S_POP,
      S_WALK,
      S_MOVE
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [31:0]        value_ff, value_in;
   logic [LW-1:0]      cur_ff, cur_in;
   logic [LW-1:0]      prev_ff, prev_in;
   logic [LW-1:0]      head_ff, head_in;
   logic [LW-1:0]      tail_ff, tail_in;
   logic [LW-1:0]      free_ff, free_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [LW-1:0]      fill_ff, fill_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   plmtf_pkg::rsp_type rsp_ff, rsp_in;

   logic [LW-1:0]      rd_slot;
   logic [31:0]        val_rdata;
   logic [LW-1:0]      link_rdata;
   logic               val_we;
   logic               link_we;
   logic [LW-1:0]      link_wslot;
   logic [LW-1:0]      link_wdata;
   logic               match;

   assign match = (val_rdata == value_ff);

   always_comb begin
      case (state_ff)
         S_IDLE: begin
            if (req_payload.cmd == plmtf_pkg::CMD_APPEND ||
                req_payload.cmd == plmtf_pkg::CMD_PUSH) begin
               rd_slot = free_ff;
            end else begin
               rd_slot = head_ff;
            end
         end
         S_WALK:  rd_slot = link_rdata;
         default: rd_slot = cur_ff;
      endcase
   end

   always_comb begin
      val_we     = (state_ff == S_ALLOC);
      link_we    = 1'b0;
      link_wslot = cur_ff;
      link_wdata = NULL_SLOT;
      case (state_ff)
         S_ALLOC: begin
            link_we    = 1'b1;
            link_wdata = (cmd_ff == plmtf_pkg::CMD_PUSH) ? head_ff : NULL_SLOT;
         end
         S_LINK_TAIL: begin
            link_we    = 1'b1;
            link_wslot = tail_ff;
            link_wdata = cur_ff;
         end
         S_POP: begin
            link_we    = 1'b1;
            link_wdata = free_ff;
         end
         S_WALK: begin
            link_we    = match && (cmd_ff == plmtf_pkg::CMD_MOVE) && (prev_ff != NULL_SLOT);
            link_wslot = prev_ff;
            link_wdata = link_rdata;
         end
         S_MOVE: begin
            link_we    = 1'b1;
            link_wdata = head_ff;
         end
         default: begin
            link_we = 1'b0;
         end
      endcase
   end

   plmtf_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_values (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (cur_ff[IW-1:0]),
      .wr_data (value_ff),
      .rd_addr (rd_slot[IW-1:0]),
      .rd_data (val_rdata)
   );

   plmtf_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_links (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wslot[IW-1:0]),
      .wr_data (link_wdata),
      .rd_addr (rd_slot[IW-1:0]),
      .rd_data (link_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      len_in        = len_ff;
      fill_in       = fill_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_payload.cmd;
               value_in = req_payload.value;
               case (req_payload.cmd)
                  plmtf_pkg::CMD_APPEND, plmtf_pkg::CMD_PUSH: begin
                     if (len_ff == NULL_SLOT) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in = plmtf_pkg::make_rsp(plmtf_pkg::STAT_FULL, '0, '0, '0);
                     end else begin
                        cur_in   = free_ff;
                        state_in = S_ALLOC;
                     end
                  end
                  plmtf_pkg::CMD_POP: begin
                     if (head_ff == NULL_SLOT) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in = plmtf_pkg::make_rsp(plmtf_pkg::STAT_EMPTY, '0, '0, '0);
                     end else begin
                        cur_in   = head_ff;
                        state_in = S_POP;
                     end
                  end
                  plmtf_pkg::CMD_FIND, plmtf_pkg::CMD_MOVE: begin
                     if (head_ff == NULL_SLOT) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in = plmtf_pkg::make_rsp(plmtf_pkg::STAT_NOTFOUND, '0, '0, '0);
                     end else begin
                        cur_in   = head_ff;
                        prev_in  = NULL_SLOT;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in = plmtf_pkg::make_rsp(plmtf_pkg::STAT_OK, '0, '0, '0);
                  end
               endcase
            end
         end
         S_ALLOC: begin
            if (cur_ff == fill_ff) begin
               free_in = LW'(cur_ff + 1'b1);
               fill_in = LW'(fill_ff + 1'b1);
            end else begin
               free_in = link_rdata;
            end
            len_in = LW'(len_ff + 1'b1);
            if (cmd_ff == plmtf_pkg::CMD_PUSH || head_ff == NULL_SLOT) begin
               head_in = cur_ff;
               if (tail_ff == NULL_SLOT) begin
                  tail_in = cur_ff;
               end
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_in = plmtf_pkg::make_rsp(plmtf_pkg::STAT_OK, '0, 4'(cur_ff), '0);
            end else begin
               state_in = S_LINK_TAIL;
            end
         end
         S_LINK_TAIL: begin
            tail_in       = cur_ff;
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_in = plmtf_pkg::make_rsp(plmtf_pkg::STAT_OK, '0, 4'(cur_ff), '0);
         end
         S_POP: begin
            head_in = link_rdata;
            if (link_rdata == NULL_SLOT) begin
               tail_in = NULL_SLOT;
            end
            free_in       = cur_ff;
            len_in        = LW'(len_ff - 1'b1);
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_in = plmtf_pkg::make_rsp(plmtf_pkg::STAT_OK, val_rdata, 4'(cur_ff), '0);
         end
         S_WALK: begin
            if (match) begin
               if (cmd_ff == plmtf_pkg::CMD_MOVE && prev_ff != NULL_SLOT) begin
                  if (cur_ff == tail_ff) begin
                     tail_in = prev_ff;
                  end
                  state_in = S_MOVE;
               end else begin
                  state_in      = S_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_in = plmtf_pkg::make_rsp(plmtf_pkg::STAT_OK, '0, 4'(cur_ff), '0);
               end
            end else if (link_rdata == NULL_SLOT) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_in = plmtf_pkg::make_rsp(plmtf_pkg::STAT_NOTFOUND, '0, '0, '0);
            end else begin
               prev_in = cur_ff;
               cur_in  = link_rdata;
            end
         end
         S_MOVE: begin
            head_in       = cur_ff;
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_in = plmtf_pkg::make_rsp(plmtf_pkg::STAT_OK, '0, 4'(cur_ff), '0);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (rsp_strobe_in) begin
         rsp_in.entry_count = 5'(len_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= NULL_SLOT;
         tail_ff       <= NULL_SLOT;
         free_ff       <= '0;
         len_ff        <= '0;
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_ff       <= free_in;
         len_ff        <= len_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff   <= cmd_in;
      value_ff <= value_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      rsp_ff   <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_ALWAYS(a_len_bound, clock, reset, len_ff <= NULL_SLOT, "list length over capacity")
   `ASSERT_ALWAYS(a_head_len, clock, reset, (head_ff == NULL_SLOT) == (len_ff == '0), "head and length disagree")
   `ASSERT_ALWAYS(a_free_len, clock, reset, (free_ff == NULL_SLOT) == (len_ff == NULL_SLOT), "free chain and length disagree")
   `ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_strobe || busy, "accepted transaction dropped")
   `ASSERT_IMPLIES(a_rsp_idle, clock, reset, rsp_strobe, !busy, "response while busy")

endmodule

@@ dv/pooled_list_move_to_front_unit_test.sv @@
// Self-checking testbench for pooled_list_move_to_front_unit: directed and random command
// streams with a cycle-free list predictor and in-order result checking.
// Depends on plmtf_pkg and the unit RTL.
module pooled_list_move_to_front_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import plmtf_pkg::*;

   localparam int         CAP            = CAPACITY_DEFAULT;
   localparam logic [4:0] LIST_END       = 5'(CAP);
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         DRAIN_CYCLES   = 40;
   localparam int         RANDOM_TARGET  = 1250;

   typedef struct {
      req_type cmd_word;
      int      idle_pct;
      bit      drain_first;
   } stimulus_item;

   logic    clock;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   stimulus_item queued_commands[$];
   rsp_type      expected_outcomes[$];
   int           in_flight;
   int           mismatch_count = 0;
   int           idle_cycles    = 0;

   logic [31:0] pool_values[CAP];
   logic [4:0]  pool_links[CAP];
   logic [4:0]  head_slot;
   logic [4:0]  tail_slot;
   logic [4:0]  free_slot;
   logic [4:0]  list_len;

   pooled_list_move_to_front_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_list();
      for (int i = 0; i < CAP; i++) begin
         pool_values[i] = '0;
         pool_links[i]  = 5'(i + 1);
      end
      head_slot = LIST_END;
      tail_slot = LIST_END;
      free_slot = '0;
      list_len  = '0;
   endfunction

   function automatic rsp_type apply_list_command(req_type c);
      rsp_type    r;
      logic [4:0] s;
      logic [4:0] prior;
      logic [4:0] walk;
      logic [4:0] walk_prev;
      int         steps;
      r        = '0;
      r.status = STAT_OK;
      case (c.cmd)
         CMD_APPEND, CMD_PUSH: begin
            if (list_len >= 5'(CAP) || free_slot >= LIST_END) begin
               r.status = STAT_FULL;
            end else begin
               s              = free_slot;
               free_slot      = pool_links[s];
               pool_values[s] = c.value;
               if (c.cmd == CMD_APPEND) begin
                  pool_links[s] = LIST_END;
                  if (head_slot >= LIST_END) head_slot = s;
                  else if (tail_slot < LIST_END) pool_links[tail_slot] = s;
                  tail_slot = s;
               end else begin
                  pool_links[s] = head_slot;
                  head_slot     = s;
                  if (tail_slot >= LIST_END) tail_slot = s;
               end
               list_len++;
               r.slot_index = s[3:0];
            end
         end
         CMD_POP: begin
            if (head_slot >= LIST_END) begin
               r.status = STAT_EMPTY;
            end else begin
               s          = head_slot;
               r.data_out = pool_values[s];
               head_slot  = pool_links[s];
               if (head_slot >= LIST_END) tail_slot = LIST_END;
               pool_links[s] = free_slot;
               free_slot     = s;
               if (list_len > 0) list_len--;
               r.slot_index = s[3:0];
            end
         end
         CMD_FIND, CMD_MOVE: begin
            s         = LIST_END;
            prior     = LIST_END;
            walk      = head_slot;
            walk_prev = LIST_END;
            steps     = 0;
            while (walk < LIST_END && steps < CAP && s == LIST_END) begin
               if (pool_values[walk] == c.value) begin
                  s     = walk;
                  prior = walk_prev;
               end else begin
                  walk_prev = walk;
                  walk      = pool_links[walk];
                  steps++;
               end
            end
            if (s == LIST_END) begin
               r.status = STAT_NOTFOUND;
            end else begin
               r.slot_index = s[3:0];
               if (c.cmd == CMD_MOVE && prior < LIST_END) begin
                  pool_links[prior] = pool_links[s];
                  if (s == tail_slot) tail_slot = prior;
                  pool_links[s] = head_slot;
                  head_slot     = s;
               end
            end
         end
         default: ;
      endcase
      r.entry_count = list_len;
      return r;
   endfunction

   task automatic enqueue(logic [2:0] cmd, logic [31:0] value, int idle_pct, bit drain_first);
      stimulus_item it;
      it.cmd_word.cmd   = cmd;
      it.cmd_word.value = value;
      it.idle_pct       = idle_pct;
      it.drain_first    = drain_first;
      queued_commands.push_back(it);
   endtask

   always @(posedge clock) begin
      stimulus_item nxt;
      bit           taken;
      bit           holding;
      bit           launch;
      if (reset) begin
         start     <= 1'b0;
         in_flight = 0;
         clear_list();
      end else begin
         taken = start && !busy;
         if (taken) begin
            expected_outcomes.push_back(apply_list_command(req_payload));
            in_flight++;
         end
         if (rsp_strobe) in_flight--;
         holding = start && !taken;
         launch  = 1'b0;
         if (!holding && queued_commands.size() > 0) begin
            nxt    = queued_commands[0];
            launch = ($urandom_range(99) >= nxt.idle_pct) && (!nxt.drain_first || in_flight == 0);
         end
         if (launch) begin
            void'(queued_commands.pop_front());
            start       <= 1'b1;
            req_payload <= nxt.cmd_word;
         end else if (!holding) begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_outcomes.size() == 0) begin
            $display("%0t unexpected transaction: expected none, actual %p", $realtime,
                     rsp_payload);
            mismatch_count++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_payload.status !== want.status) begin
               $display("%0t status: expected %0d actual %0d", $realtime, want.status,
                        rsp_payload.status);
               mismatch_count++;
            end
            if (rsp_payload.data_out !== want.data_out) begin
               $display("%0t data_out: expected %h actual %h", $realtime, want.data_out,
                        rsp_payload.data_out);
               mismatch_count++;
            end
            if (rsp_payload.slot_index !== want.slot_index) begin
               $display("%0t slot_index: expected %0d actual %0d", $realtime, want.slot_index,
                        rsp_payload.slot_index);
               mismatch_count++;
            end
            if (rsp_payload.entry_count !== want.entry_count) begin
               $display("%0t entry_count: expected %0d actual %0d", $realtime,
                        want.entry_count, rsp_payload.entry_count);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("pooled_list_move_to_front_unit regression: fail");
      $finish;
   end

   initial begin
      int          counted;
      int          chunk;
      int          mode;
      int          pick;
      int          pct;
      logic [2:0]  cmd;
      logic [31:0] value;
      logic [31:0] value_pool[6];
      int          idle_table[3];

      idle_table = '{0, 51, 6};

      enqueue(CMD_POP, 32'h0, 0, 1'b0);
      enqueue(CMD_FIND, 32'h0, 0, 1'b0);
      enqueue(CMD_MOVE, 32'h0, 0, 1'b0);
      for (int k = 5; k <= 7; k++) enqueue(3'(k), $urandom, 0, 1'b0);
      enqueue(CMD_PUSH, 32'hFFFF_FFFF, 0, 1'b0);
      enqueue(CMD_APPEND, 32'h0, 0, 1'b0);
      for (int k = 1; k <= 14; k++) enqueue(CMD_APPEND, 32'(k) * 32'h1111_1111, 0, 1'b0);
      enqueue(CMD_APPEND, 32'h1234_5678, 0, 1'b0);
      enqueue(CMD_PUSH, 32'h1234_5678, 0, 1'b0);
      enqueue(CMD_FIND, 32'hFFFF_FFFF, 0, 1'b0);
      enqueue(CMD_MOVE, 32'h0, 0, 1'b0);
      enqueue(CMD_MOVE, 32'hEEEE_EEEE, 0, 1'b0);
      enqueue(CMD_MOVE, 32'hEEEE_EEEE, 0, 1'b0);
      enqueue(CMD_FIND, 32'h7FFF_FFFE, 0, 1'b0);
      enqueue(CMD_POP, 32'h0, 0, 1'b0);

      counted = 0;
      chunk   = 0;
      while (counted < RANDOM_TARGET) begin
         mode = $urandom_range(2);
         pct  = idle_table[(counted / 100) % 3];
         for (int k = 0; k < 6; k++) begin
            pick = $urandom_range(9);
            value_pool[k] = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
         end
         for (int k = 0; k < 30; k++) begin
            pick = $urandom_range(99);
            case (mode)
               0: cmd = (pick < 30) ? CMD_APPEND : (pick < 55) ? CMD_PUSH : (pick < 65) ? CMD_POP :
                        (pick < 80) ? CMD_FIND : (pick < 98) ? CMD_MOVE : 3'($urandom_range(7, 5));
               1: cmd = (pick < 10) ? CMD_APPEND : (pick < 20) ? CMD_PUSH : (pick < 60) ? CMD_POP :
                        (pick < 78) ? CMD_FIND : (pick < 98) ? CMD_MOVE : 3'($urandom_range(7, 5));
               default: cmd = (pick < 20) ? CMD_APPEND : (pick < 38) ? CMD_PUSH :
                              (pick < 58) ? CMD_POP : (pick < 78) ? CMD_FIND :
                              (pick < 98) ? CMD_MOVE : 3'($urandom_range(7, 5));
            endcase
            value = ($urandom_range(99) < 80) ? value_pool[$urandom_range(5)] : $urandom;
            enqueue(cmd, value, pct, k == 0 && chunk % 4 == 0);
            if (cmd <= CMD_MOVE) counted++;
         end
         chunk++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (queued_commands.size() > 0 || start || expected_outcomes.size() > 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("pooled_list_move_to_front_unit regression: pass");
      end else begin
         $display("pooled_list_move_to_front_unit regression: fail");
      end
      $finish;
   end

endmodule
